// ----- sv/gray_histogram_equalizer_defines.svh -----
// Assertion macros shared by the histogram equalizer RTL.
`ifndef GRAY_HISTOGRAM_EQUALIZER_DEFINES_SVH
`define GRAY_HISTOGRAM_EQUALIZER_DEFINES_SVH

// a implies b in the same cycle
`define GHE_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define GHE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- sv/ghe_pkg.sv -----
// Types and constants of the gray histogram equalizer.
package ghe_pkg;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned GRAY_RECIP = 683;  // round-up of 2^11 / 3
  localparam int unsigned GRAY_SHIFT = 11;
  localparam int unsigned MAP_SCALE  = 255;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              mapping;
    logic              last;
  } ghe_item_t;

  typedef struct packed {
    logic      valid;
    ghe_item_t item;
  } ghe_q_t;

  typedef struct packed {
    logic pop;
    logic build_done;
    logic clearing;
  } ghe_ctl_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HWRITE,
    B_MOUT,
    B_BREAD,
    B_BACC,
    B_BDIV,
    B_BWRITE
  } ghe_back_state_t;
endpackage

// ----- sv/gray_histogram_equalizer.sv -----
// Top level: two-pass histogram equalizer of gray derived from RGB pixels.
// With the back part idle, a transaction is queued, popped in the idle state, and
// its result shown in the MOUT state; each pixel takes a memory read, then a
// write or a result; results cannot be stalled. After the last counting pixel
// the map is built bin by bin by the one-bit-per-cycle divider; busy is high
// meanwhile. Reset clears control, then sweeps all 256 histogram bins to zero.
module gray_histogram_equalizer import ghe_pkg::*; #(
  parameter int unsigned MAX_PIXEL_BITS = 22
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  input  logic                    pixel_count_we,
  input  logic [MAX_PIXEL_BITS:0] pixel_count,
  output logic                    result_strobe,
  output logic [7:0]              equalized_gray,
  output logic                    frame_done
);
  `include "gray_histogram_equalizer_defines.svh"

  localparam int unsigned CW = MAX_PIXEL_BITS + 1;

  // frame length register; zero acts as one
  logic [CW-1:0] count_reg;
  logic [CW-1:0] n;
  ghe_q_t        head;
  ghe_ctl_t      ctl;

  always_ff @(posedge clk) begin
    if (rst) count_reg <= CW'(1);
    else if (pixel_count_we) count_reg <= pixel_count;
  end

  assign n = (count_reg == '0) ? CW'(1) : count_reg;

  // front: accept transaction, gray, pass tracking, two-entry queue
  ghe_front #(.CW(CW)) u_front (
    .clk, .rst, .start, .busy, .red, .green, .blue, .n, .ctl, .head
  );

  // back: histogram memory, map build, map lookup
  ghe_back #(.CW(CW)) u_back (
    .clk, .rst, .n, .head, .ctl, .result_strobe, .equalized_gray, .frame_done
  );

  `GHE_ASSERT_IMPL(a_done_strobe, frame_done, result_strobe)
  `GHE_ASSERT_NEXT(a_strobe_gap, result_strobe, !result_strobe)
  `GHE_ASSERT_IMPL(a_build_busy, ctl.build_done, busy)
  `GHE_ASSERT_IMPL(a_clear_busy, ctl.clearing, busy)
endmodule

// ----- sv/ghe_front.sv -----
// Front part: takes pixels, forms the gray, tracks the pass and queues items.
module ghe_front import ghe_pkg::*; #(
  parameter int unsigned CW = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [CW-1:0] n,
  input  ghe_ctl_t      ctl,
  output ghe_q_t        head
);
  logic [CW-1:0] counter;
  logic          phase;
  logic          hold;
  ghe_item_t     fifo [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;
  logic          accept, last;
  logic [9:0]    sum;
  logic [20:0]   prod;
  logic [CW:0]   next_cnt;
  ghe_item_t     item;

  assign sum      = 10'(red) + 10'(green) + 10'(blue);
  assign prod     = 21'(sum) * 21'(GRAY_RECIP);
  assign next_cnt = {1'b0, counter} + (CW+1)'(1);
  assign last     = next_cnt >= {1'b0, n};
  assign busy     = fill[1] | hold | ctl.clearing;
  assign accept   = start & ~busy;

  always_comb begin
    item.gray    = prod[GRAY_SHIFT +: GRAY_W];
    item.mapping = phase;
    item.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      phase   <= 1'b0;
      hold    <= 1'b0;
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      fill    <= '0;
    end else begin
      if (accept) begin
        fifo[wr_ptr] <= item;
        wr_ptr       <= ~wr_ptr;
        if (last) begin
          counter <= '0;
          phase   <= ~phase;
          if (!phase) hold <= 1'b1;
        end else begin
          counter <= next_cnt[CW-1:0];
        end
      end
      if (ctl.build_done) hold <= 1'b0;
      if (ctl.pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(accept) - 2'(ctl.pop);
    end
  end

  assign head.valid = |fill;
  assign head.item  = fifo[rd_ptr];
endmodule

// ----- sv/ghe_back.sv -----
// Back part: histogram update, map build with serial divider, map lookup.
module ghe_back import ghe_pkg::*; #(
  parameter int unsigned CW = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] n,
  input  ghe_q_t        head,
  output ghe_ctl_t      ctl,
  output logic          result_strobe,
  output logic [7:0]    equalized_gray,
  output logic          frame_done
);
  localparam int unsigned PW = CW + 8;
  localparam int unsigned SW = $clog2(PW);

  ghe_back_state_t state, state_next;
  logic [CW-1:0]   hist [256];
  logic [7:0]      gmap [256];
  logic [CW-1:0]   hist_q;
  logic [7:0]      map_q;
  logic [7:0]      hist_raddr, hist_waddr;
  logic [CW-1:0]   hist_wdata;
  logic            hist_we;
  ghe_item_t       cur;
  logic [7:0]      idx;
  logic [CW-1:0]   sum, sum_new, rem;
  logic [PW-1:0]   quo;
  logic [SW-1:0]   steps;
  logic [CW:0]     trial;
  logic [7:0]      sat;

  assign sum_new = sum + hist_q;
  assign trial   = {rem, quo[PW-1]} - {1'b0, n};
  assign sat     = (|quo[PW-1:8]) ? 8'hFF : quo[7:0];

  always_comb begin
    hist_raddr = (state == B_IDLE) ? head.item.gray : idx;
    hist_we    = 1'b0;
    hist_waddr = idx;
    hist_wdata = '0;
    case (state)
      B_CLEAR, B_BACC: hist_we = 1'b1;
      B_HWRITE: begin
        hist_we    = 1'b1;
        hist_waddr = cur.gray;
        hist_wdata = hist_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_waddr] <= hist_wdata;
    hist_q <= hist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == B_BWRITE) gmap[idx] <= sat;
    map_q <= gmap[head.item.gray];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR:  if (idx == 8'hFF) state_next = B_IDLE;
      B_IDLE:   if (head.valid) state_next = head.item.mapping ? B_MOUT : B_HWRITE;
      B_HWRITE: state_next = cur.last ? B_BREAD : B_IDLE;
      B_MOUT:   state_next = B_IDLE;
      B_BREAD:  state_next = B_BACC;
      B_BACC:   state_next = B_BDIV;
      B_BDIV:   if (steps == SW'(PW-1)) state_next = B_BWRITE;
      B_BWRITE: state_next = (idx == 8'hFF) ? B_IDLE : B_BREAD;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    ctl.pop        = (state == B_IDLE) & head.valid;
    ctl.build_done = (state == B_BWRITE) & (idx == 8'hFF);
    ctl.clearing   = (state == B_CLEAR);
    result_strobe  = (state == B_MOUT);
    equalized_gray = map_q;
    frame_done     = (state == B_MOUT) & cur.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        B_CLEAR:  idx <= idx + 8'd1;
        B_HWRITE: idx <= '0;
        B_BWRITE: idx <= idx + 8'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE:   cur <= head.item;
      B_HWRITE: sum <= '0;
      B_BACC: begin
        sum   <= sum_new;
        quo   <= {sum_new, 8'd0} - PW'(sum_new);
        rem   <= '0;
        steps <= '0;
      end
      B_BDIV: begin
        steps <= steps + SW'(1);
        if (!trial[CW]) begin
          rem <= trial[CW-1:0];
          quo <= {quo[PW-2:0], 1'b1};
        end else begin
          rem <= {rem[CW-2:0], quo[PW-1]};
          quo <= {quo[PW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- sim/tb_gray_histogram_equalizer.sv -----
// Testbench of the two-pass gray histogram equalizer: directed and random frames.
module tb_gray_histogram_equalizer;
  import ghe_pkg::*;

  localparam int unsigned PIX_BITS   = 22;
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned CNT_MASK   = (1 << (PIX_BITS + 1)) - 1;
  localparam int unsigned IDLE_LIMIT = 100000;  // longer than a map build
  localparam int unsigned SETTLE     = 16;      // back-end drain after last pixel
  localparam int unsigned RAND_ITEMS = 2000;

  typedef struct {
    logic [GRAY_W-1:0] gray;
    logic              done;
  } eq_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic                pixel_count_we;
  logic [PIX_BITS:0]   pixel_count;
  logic                result_strobe;
  logic [7:0]          equalized_gray;
  logic                frame_done;

  // shadow state of the equalizer
  int unsigned         frame_len;
  bit                  in_mapping;
  int unsigned         pix_idx;
  int unsigned         hist_bins [LEVELS];
  logic [7:0]          level_map [LEVELS];
  bit                  frame_closed;   // set when a mapping pass ends

  eq_result_t          pending_grays[$];
  int unsigned         errors;
  int unsigned         pixels_sent;
  int unsigned         idle_cycles;

  gray_histogram_equalizer #(.MAX_PIXEL_BITS(PIX_BITS)) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .pixel_count_we (pixel_count_we),
    .pixel_count    (pixel_count),
    .result_strobe  (result_strobe),
    .equalized_gray (equalized_gray),
    .frame_done     (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Cumulative map: floor(255*cum/N), saturated when the count shrank mid-pass.
  task automatic rebuild_map();
    longint unsigned n;
    longint unsigned v;
    int unsigned     cum;
    n   = (frame_len == 0) ? 1 : frame_len;
    cum = 0;
    for (int i = 0; i < LEVELS; i++) begin
      cum = (cum + hist_bins[i]) & CNT_MASK;
      v   = (longint'(MAP_SCALE) * cum) / n;
      level_map[i] = (v > 255) ? 8'd255 : v[7:0];
      hist_bins[i] = 0;
    end
  endtask

  // Advance the shadow state by one accepted pixel; queue a result if one is due.
  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    logic [9:0]  sum;
    logic [7:0]  gray;
    bit          last;
    eq_result_t  res;
    sum  = r + g + b;
    gray = 8'(sum / 3);
    last = (pix_idx + 1) >= ((frame_len == 0) ? 1 : frame_len);
    if (!in_mapping) begin
      hist_bins[gray] = (hist_bins[gray] + 1) & CNT_MASK;
      if (last) begin
        rebuild_map();
        pix_idx    = 0;
        in_mapping = 1'b1;
      end else begin
        pix_idx = (pix_idx + 1) & CNT_MASK;
      end
    end else begin
      res.gray = level_map[gray];
      res.done = last;
      pending_grays.push_back(res);
      if (last) begin
        pix_idx      = 0;
        in_mapping   = 1'b0;
        frame_closed = 1'b1;
      end else begin
        pix_idx = (pix_idx + 1) & CNT_MASK;
      end
    end
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One pixel transaction; caller is aligned just after a rising edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    do @(posedge clk); while (busy);
    predict_pixel(r, g, b);
    pixels_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write with the block idle: no results owed, back end drained.
  task automatic write_frame_len(input int unsigned val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_grays.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    pixel_count_we <= 1'b1;
    pixel_count    <= (PIX_BITS+1)'(val);
    @(posedge clk);
    frame_len = val & CNT_MASK;
    pixel_count_we <= 1'b0;
  endtask

  task automatic send_random_pixel();
    logic [7:0] base;
    // half the pixels have near-equal channels around a random base level
    if ($urandom_range(0, 1)) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      base = 8'($urandom);
      send_pixel(base, base ^ 8'($urandom_range(0, 3)), base);
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is a transaction.
  always @(posedge clk) begin
    eq_result_t want;
    if (!rst && result_strobe) begin
      if (pending_grays.size() == 0) begin
        report($sformatf("unexpected result gray=%0d done=%0b", equalized_gray, frame_done));
      end else begin
        want = pending_grays.pop_front();
        if (equalized_gray !== want.gray)
          report($sformatf("equalized_gray %0d, want %0d", equalized_gray, want.gray));
        if (frame_done !== want.done)
          report($sformatf("frame_done %0b, want %0b", frame_done, want.done));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset value of the count is 1: one counting pixel, one mapped pixel.
  task automatic test_default_count();
    send_pixel(8'd10, 8'd20, 8'd30);
    send_pixel(8'd10, 8'd20, 8'd30);
  endtask

  // Channel extremes across a six-pixel frame, both passes.
  task automatic test_channel_extremes();
    write_frame_len(6);
    for (int pass = 0; pass < 2; pass++) begin
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd254);
    end
  endtask

  // A zero count behaves like one.
  task automatic test_zero_count();
    write_frame_len(0);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd200, 8'd100, 8'd50);
  endtask

  // Full-scale count, then shrunk below the pixels already taken: the pass
  // closes on the next pixel and the map saturates at 255.
  task automatic test_count_shrunk();
    write_frame_len(CNT_MASK);
    repeat (4) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    write_frame_len(3);
    send_pixel(8'd90, 8'd90, 8'd90);
    repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Random frames, mostly small; occasionally a larger one or a count
  // shrunk partway through the frame.
  task automatic test_random_frames();
    int unsigned len;
    int unsigned cut;
    int unsigned n;
    while (pixels_sent < RAND_ITEMS) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
      write_frame_len(len);
      frame_closed = 1'b0;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 0;
      n   = 0;
      while (!frame_closed) begin
        if (cut != 0 && n == cut) write_frame_len($urandom_range(0, len));
        send_random_pixel();
        n++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    red            = '0;
    green          = '0;
    blue           = '0;
    pixel_count_we = 1'b0;
    pixel_count    = '0;
    errors         = 0;
    pixels_sent    = 0;
    frame_len      = 1;
    in_mapping     = 1'b0;
    pix_idx        = 0;
    frame_closed   = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      hist_bins[i] = 0;
      level_map[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_default_count();
    test_channel_extremes();
    test_zero_count();
    test_count_shrunk();
    pixels_sent = 0;
    test_random_frames();

    start <= 1'b0;
    while (pending_grays.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/ghe_pkg.sv
sv/ghe_front.sv
sv/ghe_back.sv
sv/gray_histogram_equalizer.sv
sim/tb_gray_histogram_equalizer.sv
